[sv/tween_easing_engine_macros.svh]
// Assertion macros for the tween easing engine checker
`ifndef TWEEN_EASING_ENGINE_MACROS_SVH
`define TWEEN_EASING_ENGINE_MACROS_SVH
// same-cycle implication, disabled in reset
`define TEE_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
// next-cycle implication, disabled in reset
`define TEE_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
// same-cycle implication, live through reset
`define TEE_ASSERT_ALWAYS(label, ante, cons, msg) \
   label: assert property (@(posedge clock) (ante) |-> (cons)) else $error(msg);
`endif

[sv/tee_pkg.sv]
// Shared types and constants of the tween easing engine
`default_nettype none
package tee_pkg;
   localparam int MUL_W      = 34;
   localparam int PROD_W     = 68;
   localparam int DIVD_W     = 64;
   localparam int DIVS_W     = 16;
   localparam int DIV_STEPS  = 64;
   localparam int EASE_W     = 19;
   localparam int TAYLOR_TERMS = 12;

   typedef enum logic [1:0] {
      OP_START  = 2'd0,
      OP_REPEAT = 2'd1,
      OP_STOP   = 2'd2,
      OP_ADV    = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      CRV_LINEAR = 2'd0,
      CRV_OUT3   = 2'd1,
      CRV_INOUT3 = 2'd2,
      CRV_SPRING = 2'd3
   } curve_type;

   typedef struct packed {
      logic signed [31:0] start_val;
      logic signed [31:0] target_val;
      logic signed [31:0] present_val;
      logic signed [47:0] start_time;
      logic [15:0]        duration;
      logic [1:0]         curve;
   } slot_rec_type;

   typedef struct packed {
      logic              start;
      logic [DIVD_W-1:0] dividend;
      logic [DIVS_W-1:0] divisor;
   } div_req_type;
endpackage
`default_nettype wire

[sv/tee_mul.sv]
// Shared signed multiplier with registered product
`default_nettype none
module tee_mul (
   input  wire logic                              clock,
   input  wire logic signed [tee_pkg::MUL_W-1:0]  a,
   input  wire logic signed [tee_pkg::MUL_W-1:0]  b,
   output logic signed [tee_pkg::PROD_W-1:0]      p
);
   logic signed [tee_pkg::PROD_W-1:0] p_ff;

   always_ff @(posedge clock) begin
      p_ff <= tee_pkg::PROD_W'(a) * tee_pkg::PROD_W'(b);
   end

   assign p = p_ff;
endmodule
`default_nettype wire

[sv/tee_div.sv]
// Restoring divider, one quotient bit per cycle
`default_nettype none
module tee_div (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire tee_pkg::div_req_type       req,
   output logic                            done,
   output logic [tee_pkg::DIVD_W-1:0]      quotient
);
   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [6:0]                    cnt_ff, cnt_in;
   logic [tee_pkg::DIVS_W-1:0]    rem_ff, rem_in;
   logic [tee_pkg::DIVD_W-1:0]    quo_ff, quo_in;
   logic [tee_pkg::DIVS_W-1:0]    dvs_ff, dvs_in;
   logic [tee_pkg::DIVS_W:0]      rem_sh;
   logic [tee_pkg::DIVS_W:0]      rem_sub;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      rem_sh  = {rem_ff, quo_ff[tee_pkg::DIVD_W-1]};
      rem_sub = rem_sh - {1'b0, dvs_ff};
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = 7'(tee_pkg::DIV_STEPS);
         rem_in  = '0;
         quo_in  = req.dividend;
         dvs_in  = req.divisor;
      end else if (busy_ff) begin
         if (rem_sh >= {1'b0, dvs_ff}) begin
            rem_in = rem_sub[tee_pkg::DIVS_W-1:0];
            quo_in = {quo_ff[tee_pkg::DIVD_W-2:0], 1'b1};
         end else begin
            rem_in = rem_sh[tee_pkg::DIVS_W-1:0];
            quo_in = {quo_ff[tee_pkg::DIVD_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == 7'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;
endmodule
`default_nettype wire

[sv/tee_slot_store.sv]
// Slot record memory with per-slot valid bits
`default_nettype none
module tee_slot_store #(
   parameter int NUM_SLOTS = 8,
   parameter int AW        = 3
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  wr_en,
   input  wire logic [AW-1:0]         wr_addr,
   input  wire tee_pkg::slot_rec_type wr_data,
   input  wire logic [AW-1:0]         rd_addr,
   output tee_pkg::slot_rec_type      rd_data
);
   tee_pkg::slot_rec_type mem [NUM_SLOTS];
   logic [NUM_SLOTS-1:0]  valid_ff;
   tee_pkg::slot_rec_type rd_ff;
   logic                  rd_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_ff       <= mem[rd_addr];
      rd_valid_ff <= valid_ff[rd_addr];
   end

   assign rd_data = rd_valid_ff ? rd_ff : '0;
endmodule
`default_nettype wire

[sv/tween_easing_engine.sv]
// Tween easing engine top level: sequencer, spring table and result register
//
//   channel | direction | handshake           | payload
//   req     | in        | req_valid/req_ready | operation, slot, values, duration, curve, time
//   rsp     | out       | rsp_valid/rsp_ready | result_slot, current_value, flags, last
//
// After reset the spring table is built, with req_ready low throughout.
// Start writes the slot record and emits; stop reads the slot, settles it if running and emits.
// Advance visits every slot in turn and emits a result for each; a running slot also waits on
// the 64-step shared divider forming the phase before its curve and value steps.
// A stalled rsp holds the sequencer at its emit step; each result needs one rsp transaction.
`default_nettype none
module tween_easing_engine #(
   parameter int NUM_SLOTS          = 8,
   parameter int SPRING_TABLE_DEPTH = 256
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [1:0]         req_operation,
   input  wire logic [2:0]         req_slot,
   input  wire logic signed [31:0] req_from_value,
   input  wire logic signed [31:0] req_to_value,
   input  wire logic [15:0]        req_duration,
   input  wire logic [1:0]         req_curve,
   input  wire logic signed [47:0] req_time_now,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic [2:0]              rsp_result_slot,
   output logic signed [31:0]      rsp_current_value,
   output logic                    rsp_still_running,
   output logic                    rsp_any_busy,
   output logic                    rsp_last
);
   localparam int AW   = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int RA_W = $clog2(SPRING_TABLE_DEPTH);
   localparam int MW   = tee_pkg::MUL_W;
   localparam int PW   = tee_pkg::PROD_W;
   localparam int EW   = tee_pkg::EASE_W;
   localparam longint WR_L = -((longint'(6) <<< 30) / SPRING_TABLE_DEPTH);
   localparam longint WI_L = (longint'(6) <<< 30) / SPRING_TABLE_DEPTH;
   localparam logic signed [MW-1:0] SPR_WR = MW'(WR_L);
   localparam logic signed [MW-1:0] SPR_WI = MW'(WI_L);
   localparam logic signed [MW-1:0] ONE_Q30 = MW'(longint'(1) <<< 30);

   typedef enum logic [25:0] {
      ST_IDLE   = 26'h0000001,
      ST_CM0    = 26'h0000002,
      ST_CM1    = 26'h0000004,
      ST_CM2    = 26'h0000008,
      ST_CM3    = 26'h0000010,
      ST_CM4    = 26'h0000020,
      ST_TDRE   = 26'h0000040,
      ST_TDRE_W = 26'h0000080,
      ST_TDIM   = 26'h0000100,
      ST_TDIM_W = 26'h0000200,
      ST_KWR    = 26'h0000400,
      ST_START  = 26'h0000800,
      ST_SREAD  = 26'h0001000,
      ST_STOP   = 26'h0002000,
      ST_EMIT1  = 26'h0004000,
      ST_AREAD  = 26'h0008000,
      ST_ACHECK = 26'h0010000,
      ST_ADIV   = 26'h0020000,
      ST_SQ     = 26'h0040000,
      ST_CUBE   = 26'h0080000,
      ST_ECUBE  = 26'h0100000,
      ST_ROM    = 26'h0200000,
      ST_EROM   = 26'h0400000,
      ST_VMUL   = 26'h0800000,
      ST_VFIN   = 26'h1000000,
      ST_AEMIT  = 26'h2000000
   } state_type;

   state_type state_ff, state_in;
   logic                 phase_ff, phase_in;
   logic [3:0]           n_ff, n_in;
   logic [RA_W-1:0]      k_ff, k_in;
   logic signed [MW-1:0] tr_ff, tr_in, ti_ff, ti_in, zr_ff, zr_in, zi_ff, zi_in;
   logic signed [MW-1:0] cr_ff, cr_in, ci_ff, ci_in, re_ff, re_in, im_ff, im_in;
   logic signed [PW-1:0] acc_ff, acc_in;

   logic [1:0]           op_ff, op_in;
   logic [2:0]           slot_ff, slot_in;
   logic signed [31:0]   from_ff, from_in, to_ff, to_in;
   logic [15:0]          dur_ff, dur_in;
   logic [1:0]           curve_ff, curve_in;
   logic signed [47:0]   now_ff, now_in;
   logic [AW-1:0]        idx_ff, idx_in;
   logic                 busy_acc_ff, busy_acc_in;
   logic signed [31:0]   res_val_ff, res_val_in;
   logic                 res_run_ff, res_run_in;
   logic [15:0]          t_ff, t_in;
   logic signed [EW-1:0] ease_ff, ease_in;
   logic [NUM_SLOTS-1:0] running_ff, running_in, repeat_ff, repeat_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [2:0]           rsp_slot_ff, rsp_slot_in;
   logic signed [31:0]   rsp_val_ff, rsp_val_in;
   logic                 rsp_run_ff, rsp_run_in, rsp_busy_ff, rsp_busy_in;
   logic                 rsp_last_ff, rsp_last_in;

   logic signed [EW-1:0] rom_mem [SPRING_TABLE_DEPTH];
   logic signed [EW-1:0] rom_rd_ff;
   logic [31:0]          t_scaled;
   logic [RA_W-1:0]      rom_addr;
   logic signed [MW-1:0] rom_shift;
   logic signed [MW-1:0] rom_entry;

   logic                  st_wr_en;
   logic [AW-1:0]         st_wr_addr, st_rd_addr, slot_addr;
   tee_pkg::slot_rec_type st_wr_data, rec;
   logic [6:0]            slot_w, idx_w;

   logic signed [MW-1:0] mul_a, mul_b;
   logic signed [PW-1:0] mul_p;
   tee_pkg::div_req_type div_req;
   logic                 div_done;
   logic [tee_pkg::DIVD_W-1:0] div_q;

   logic                 accept, out_free, idx_last;
   logic signed [MW-1:0] ar, ai, br, bi;
   logic signed [48:0]   elapsed;
   logic [47:0]          e_val;
   logic                 finish;
   logic [16:0]          cube_h;
   logic [16:0]          cube_b;
   logic signed [MW-1:0] diff;
   logic signed [PW-1:0] vsum;
   logic signed [31:0]   vsat;
   logic signed [MW-1:0] div_abs;
   logic signed [MW-1:0] q_signed;

   tee_mul u_mul (.clock(clock), .a(mul_a), .b(mul_b), .p(mul_p));

   tee_div u_div (
      .clock(clock), .reset(reset), .req(div_req), .done(div_done), .quotient(div_q)
   );

   tee_slot_store #(.NUM_SLOTS(NUM_SLOTS), .AW(AW)) u_store (
      .clock(clock), .reset(reset), .wr_en(st_wr_en), .wr_addr(st_wr_addr),
      .wr_data(st_wr_data), .rd_addr(st_rd_addr), .rd_data(rec)
   );

   assign slot_w     = 7'(slot_ff);
   assign slot_addr  = slot_w[AW-1:0];
   assign idx_w      = 7'(idx_ff);
   assign idx_last   = (idx_ff == AW'(NUM_SLOTS - 1));
   assign st_rd_addr = (op_ff == tee_pkg::OP_ADV) ? idx_ff : slot_addr;
   assign req_ready  = (state_ff == ST_IDLE);
   assign accept     = req_valid && req_ready;
   assign out_free   = !rsp_valid_ff || rsp_ready;

   assign ar = phase_ff ? cr_ff : tr_ff;
   assign ai = phase_ff ? ci_ff : ti_ff;
   assign br = phase_ff ? zr_ff : SPR_WR;
   assign bi = phase_ff ? zi_ff : SPR_WI;

   assign t_scaled  = 32'(t_ff) * 32'(SPRING_TABLE_DEPTH);
   assign rom_addr  = t_scaled[16 +: RA_W];
   assign rom_shift = cr_ff >>> 14;
   assign rom_entry = MW'(65536) - rom_shift;

   assign elapsed = {now_ff[47], now_ff} - {rec.start_time[47], rec.start_time};
   assign e_val   = elapsed[48] ? 48'd0 : elapsed[47:0];
   assign finish  = (rec.duration == 16'd0) ||
                    (!repeat_ff[idx_ff] && (e_val >= {32'd0, rec.duration}));

   assign diff = MW'(rec.target_val) - MW'(rec.start_val);
   assign vsum = PW'(rec.start_val) + (mul_p >>> 16);
   assign vsat = (vsum > PW'(64'sh7FFFFFFF)) ? 32'sh7FFFFFFF :
                 (vsum < -PW'(64'sh80000000)) ? 32'sh80000000 : vsum[31:0];

   assign div_abs  = (state_ff == ST_TDRE) ? (re_ff[MW-1] ? -re_ff : re_ff)
                                           : (im_ff[MW-1] ? -im_ff : im_ff);
   assign q_signed = ((state_ff == ST_TDRE_W) ? re_ff[MW-1] : im_ff[MW-1])
                     ? -div_q[MW-1:0] : div_q[MW-1:0];

   assign cube_h = 17'd65536 - {1'b0, t_ff};

   always_comb begin
      if (curve_ff == tee_pkg::CRV_OUT3) begin
         cube_b = cube_h;
      end else if (!t_ff[15]) begin
         cube_b = {1'b0, t_ff};
      end else begin
         cube_b = {cube_h[15:0], 1'b0};
      end
   end

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         ST_CM0:  begin mul_a = ar; mul_b = br; end
         ST_CM1:  begin mul_a = ai; mul_b = bi; end
         ST_CM2:  begin mul_a = ar; mul_b = bi; end
         ST_CM3:  begin mul_a = ai; mul_b = br; end
         ST_SQ:   begin mul_a = MW'(cube_b); mul_b = MW'(cube_b); end
         ST_CUBE: begin mul_a = mul_p[MW-1:0]; mul_b = MW'(cube_b); end
         ST_VMUL: begin mul_a = diff; mul_b = MW'(ease_ff); end
         default: begin mul_a = '0; mul_b = '0; end
      endcase
   end

   always_comb begin
      div_req.start    = (state_ff == ST_TDRE) || (state_ff == ST_TDIM) ||
                         ((state_ff == ST_ACHECK) && running_ff[idx_ff] && !finish);
      div_req.dividend = (state_ff == ST_ACHECK) ? {e_val, 16'd0}
                                                 : tee_pkg::DIVD_W'(unsigned'(div_abs));
      div_req.divisor  = (state_ff == ST_ACHECK) ? rec.duration : 16'(n_ff);
   end

   always_comb begin
      state_in    = state_ff;
      phase_in    = phase_ff;
      n_in        = n_ff;
      k_in        = k_ff;
      tr_in = tr_ff; ti_in = ti_ff; zr_in = zr_ff; zi_in = zi_ff;
      cr_in = cr_ff; ci_in = ci_ff; re_in = re_ff; im_in = im_ff;
      acc_in      = acc_ff;
      op_in = op_ff; slot_in = slot_ff; from_in = from_ff; to_in = to_ff;
      dur_in = dur_ff; curve_in = curve_ff; now_in = now_ff;
      idx_in      = idx_ff;
      busy_acc_in = busy_acc_ff;
      res_val_in  = res_val_ff;
      res_run_in  = res_run_ff;
      t_in        = t_ff;
      ease_in     = ease_ff;
      running_in  = running_ff;
      repeat_in   = repeat_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_slot_in = rsp_slot_ff;
      rsp_val_in  = rsp_val_ff;
      rsp_run_in  = rsp_run_ff;
      rsp_busy_in = rsp_busy_ff;
      rsp_last_in = rsp_last_ff;
      st_wr_en    = 1'b0;
      st_wr_addr  = st_rd_addr;
      st_wr_data  = rec;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               op_in = req_operation; slot_in = req_slot;
               from_in = req_from_value; to_in = req_to_value;
               dur_in = req_duration; curve_in = req_curve; now_in = req_time_now;
               idx_in = '0;
               busy_acc_in = 1'b0;
               if (req_operation == tee_pkg::OP_ADV) begin
                  state_in = ST_AREAD;
               end else if (32'(req_slot) >= 32'(NUM_SLOTS)) begin
                  res_val_in = '0;
                  res_run_in = 1'b0;
                  state_in   = ST_EMIT1;
               end else if (req_operation == tee_pkg::OP_STOP) begin
                  state_in = ST_SREAD;
               end else begin
                  state_in = ST_START;
               end
            end
         end
         ST_CM0: state_in = ST_CM1;
         ST_CM1: begin
            acc_in   = mul_p;
            state_in = ST_CM2;
         end
         ST_CM2: begin
            re_in    = MW'((acc_ff - mul_p) >>> 30);
            state_in = ST_CM3;
         end
         ST_CM3: begin
            acc_in   = mul_p;
            state_in = ST_CM4;
         end
         ST_CM4: begin
            im_in = MW'((acc_ff + mul_p) >>> 30);
            if (phase_ff) begin
               cr_in    = re_ff;
               ci_in    = MW'((acc_ff + mul_p) >>> 30);
               k_in     = k_ff + RA_W'(1);
               state_in = ST_KWR;
            end else begin
               state_in = ST_TDRE;
            end
         end
         ST_TDRE: state_in = ST_TDRE_W;
         ST_TDRE_W: begin
            if (div_done) begin
               tr_in    = q_signed;
               zr_in    = zr_ff + q_signed;
               state_in = ST_TDIM;
            end
         end
         ST_TDIM: state_in = ST_TDIM_W;
         ST_TDIM_W: begin
            if (div_done) begin
               ti_in = q_signed;
               zi_in = zi_ff + q_signed;
               n_in  = n_ff + 4'd1;
               if (n_ff == 4'(tee_pkg::TAYLOR_TERMS)) begin
                  phase_in = 1'b1;
                  state_in = ST_KWR;
               end else begin
                  state_in = ST_CM0;
               end
            end
         end
         ST_KWR: begin
            state_in = (k_ff == RA_W'(SPRING_TABLE_DEPTH - 1)) ? ST_IDLE : ST_CM0;
         end
         ST_START: begin
            st_wr_en               = 1'b1;
            st_wr_addr             = slot_addr;
            st_wr_data.start_val   = from_ff;
            st_wr_data.target_val  = to_ff;
            st_wr_data.present_val = (dur_ff == 16'd0) ? to_ff : from_ff;
            st_wr_data.start_time  = now_ff;
            st_wr_data.duration    = dur_ff;
            st_wr_data.curve       = curve_ff;
            running_in[slot_addr]  = (dur_ff != 16'd0);
            repeat_in[slot_addr]   = (op_ff == tee_pkg::OP_REPEAT);
            res_val_in             = (dur_ff == 16'd0) ? to_ff : from_ff;
            res_run_in             = (dur_ff != 16'd0);
            state_in               = ST_EMIT1;
         end
         ST_SREAD: state_in = ST_STOP;
         ST_STOP: begin
            res_run_in = 1'b0;
            if (running_ff[slot_addr]) begin
               running_in[slot_addr]  = 1'b0;
               repeat_in[slot_addr]   = 1'b0;
               st_wr_en               = 1'b1;
               st_wr_data.present_val = rec.target_val;
               res_val_in             = rec.target_val;
            end else begin
               res_val_in = rec.present_val;
            end
            state_in = ST_EMIT1;
         end
         ST_EMIT1: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_slot_in  = slot_ff;
               rsp_val_in   = res_val_ff;
               rsp_run_in   = res_run_ff;
               rsp_busy_in  = |running_ff;
               rsp_last_in  = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_AREAD: state_in = ST_ACHECK;
         ST_ACHECK: begin
            res_run_in = 1'b0;
            if (!running_ff[idx_ff]) begin
               res_val_in = rec.present_val;
               state_in   = ST_AEMIT;
            end else if (finish) begin
               st_wr_en               = 1'b1;
               st_wr_data.present_val = rec.target_val;
               running_in[idx_ff]     = 1'b0;
               res_val_in             = rec.target_val;
               state_in               = ST_AEMIT;
            end else begin
               curve_in = rec.curve;
               state_in = ST_ADIV;
            end
         end
         ST_ADIV: begin
            if (div_done) begin
               t_in = div_q[15:0];
               unique case (curve_ff)
                  tee_pkg::CRV_LINEAR: begin
                     ease_in  = EW'({1'b0, div_q[15:0]});
                     state_in = ST_VMUL;
                  end
                  tee_pkg::CRV_SPRING: state_in = ST_ROM;
                  default:             state_in = ST_SQ;
               endcase
            end
         end
         ST_SQ:   state_in = ST_CUBE;
         ST_CUBE: state_in = ST_ECUBE;
         ST_ECUBE: begin
            if (curve_ff == tee_pkg::CRV_OUT3) begin
               ease_in = EW'(65536) - EW'({1'b0, mul_p[48:32]});
            end else if (!t_ff[15]) begin
               ease_in = EW'({1'b0, mul_p[46:30]});
            end else begin
               ease_in = EW'(65536) - EW'({1'b0, mul_p[49:33]});
            end
            state_in = ST_VMUL;
         end
         ST_ROM: state_in = ST_EROM;
         ST_EROM: begin
            ease_in  = rom_rd_ff;
            state_in = ST_VMUL;
         end
         ST_VMUL: state_in = ST_VFIN;
         ST_VFIN: begin
            st_wr_en               = 1'b1;
            st_wr_data.present_val = vsat;
            res_val_in             = vsat;
            res_run_in             = 1'b1;
            busy_acc_in            = 1'b1;
            state_in               = ST_AEMIT;
         end
         ST_AEMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_slot_in  = idx_w[2:0];
               rsp_val_in   = res_val_ff;
               rsp_run_in   = res_run_ff;
               rsp_busy_in  = idx_last && busy_acc_ff;
               rsp_last_in  = idx_last;
               if (idx_last) begin
                  state_in = ST_IDLE;
               end else begin
                  idx_in   = idx_ff + AW'(1);
                  state_in = ST_AREAD;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CM0;
         phase_ff     <= 1'b0;
         n_ff         <= 4'd1;
         k_ff         <= '0;
         tr_ff        <= ONE_Q30;
         ti_ff        <= '0;
         zr_ff        <= ONE_Q30;
         zi_ff        <= '0;
         cr_ff        <= ONE_Q30;
         ci_ff        <= '0;
         running_ff   <= '0;
         repeat_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         n_ff         <= n_in;
         k_ff         <= k_in;
         tr_ff        <= tr_in;
         ti_ff        <= ti_in;
         zr_ff        <= zr_in;
         zi_ff        <= zi_in;
         cr_ff        <= cr_in;
         ci_ff        <= ci_in;
         running_ff   <= running_in;
         repeat_ff    <= repeat_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      re_ff       <= re_in;
      im_ff       <= im_in;
      acc_ff      <= acc_in;
      op_ff       <= op_in;
      slot_ff     <= slot_in;
      from_ff     <= from_in;
      to_ff       <= to_in;
      dur_ff      <= dur_in;
      curve_ff    <= curve_in;
      now_ff      <= now_in;
      idx_ff      <= idx_in;
      busy_acc_ff <= busy_acc_in;
      res_val_ff  <= res_val_in;
      res_run_ff  <= res_run_in;
      t_ff        <= t_in;
      ease_ff     <= ease_in;
      rsp_slot_ff <= rsp_slot_in;
      rsp_val_ff  <= rsp_val_in;
      rsp_run_ff  <= rsp_run_in;
      rsp_busy_ff <= rsp_busy_in;
      rsp_last_ff <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_KWR) begin
         rom_mem[k_ff] <= rom_entry[EW-1:0];
      end
      rom_rd_ff <= rom_mem[rom_addr];
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_result_slot   = rsp_slot_ff;
   assign rsp_current_value = rsp_val_ff;
   assign rsp_still_running = rsp_run_ff;
   assign rsp_any_busy      = rsp_busy_ff;
   assign rsp_last          = rsp_last_ff;
endmodule
`default_nettype wire

[sv/tee_checker.sv]
// Port-level checker for the tween easing engine, bound to the top level
`default_nettype none
`include "tween_easing_engine_macros.svh"
module tee_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [2:0]  rsp_result_slot,
   input wire logic [31:0] rsp_current_value,
   input wire logic        rsp_still_running,
   input wire logic        rsp_any_busy,
   input wire logic        rsp_last
);
   `TEE_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_current_value) && $stable(rsp_result_slot) &&
      $stable(rsp_last) && $stable(rsp_still_running) && $stable(rsp_any_busy),
      "rsp transaction changed while stalled")
   `TEE_ASSERT_NEXT(a_one_at_a_time, req_valid && req_ready, !req_ready,
      "req accepted on consecutive cycles")
   `TEE_ASSERT_ALWAYS(a_reset_quiet, $past(reset) && !reset, !rsp_valid && !req_ready,
      "activity straight after reset")
   `TEE_ASSERT_SAME(a_busy_on_last, rsp_valid && !rsp_last, !rsp_any_busy,
      "any_busy set before last result")
endmodule

bind tween_easing_engine tee_checker u_tee_checker (.*);
`default_nettype wire
